FILE: src/assert_macros.svh
// Assertion helpers used by the RTL. Each use stands on a line of its own
// and carries its own terminating semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BQD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bqd assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define BQD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqd assertion failed: next-cycle implication");

`endif

FILE: src/bqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared constants, control types and the microcode program of the biquad.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int COEF_WIDTH      = 20;
  localparam int NUM_COEF        = 5;
  localparam int CFG_INDEX_W     = 3;
  localparam int STEP_W          = 3;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF      = 40;

  localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET = 20'sd65536;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ZERO     = 20'sd0;

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_B0 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_B1 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_OUT_Y  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_A1 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_A2 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_FB_TWO = 3'd6;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd7;

  // Coefficient codes double as configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_SRC_S1_RND = 2'd0,
    ACC_SRC_S2     = 2'd1,
    ACC_SRC_ZERO   = 2'd2,
    ACC_SRC_SELF   = 2'd3
  } acc_src_t;

  typedef enum logic [1:0] {
    JMP_NEVER    = 2'd0,
    JMP_NO_IN    = 2'd1,
    JMP_OUT_FULL = 2'd2
  } jmp_cond_t;

  typedef struct packed {
    logic              mul_en;
    coef_sel_t         mul_sel;
    logic              mul_y;
    logic              acc_en;
    logic              acc_dst;
    acc_src_t          acc_src;
    logic              acc_sub;
    logic              y_load;
    logic              commit;
    jmp_cond_t         jmp_cond;
    logic [STEP_W-1:0] jmp_tgt;
  } ucode_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    coef_sel_t mul_sel;
    logic      mul_y;
    logic      acc_en;
    logic      acc_dst;
    acc_src_t  acc_src;
    logic      acc_sub;
    logic      y_load;
    logic      commit;
  } dp_ctrl_t;

  // One control word per step. Each product is accumulated in the next step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.mul_sel  = COEF_B0;
    w.acc_src  = ACC_SRC_ZERO;
    w.jmp_cond = JMP_NEVER;
    w.jmp_tgt  = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.jmp_cond = JMP_NO_IN;
        w.jmp_tgt  = STEP_IDLE;
      end
      STEP_MUL_B0: begin
        w.mul_en  = 1'b1;
        w.mul_sel = COEF_B0;
      end
      STEP_MUL_B1: begin
        w.mul_en  = 1'b1;
        w.mul_sel = COEF_B1;
        w.acc_en  = 1'b1;
        w.acc_dst = 1'b0;
        w.acc_src = ACC_SRC_S1_RND;
      end
      STEP_OUT_Y: begin
        w.mul_en  = 1'b1;
        w.mul_sel = COEF_B2;
        w.acc_en  = 1'b1;
        w.acc_dst = 1'b1;
        w.acc_src = ACC_SRC_S2;
        w.y_load  = 1'b1;
      end
      STEP_MUL_A1: begin
        w.mul_en  = 1'b1;
        w.mul_sel = COEF_A1;
        w.mul_y   = 1'b1;
        w.acc_en  = 1'b1;
        w.acc_dst = 1'b0;
        w.acc_src = ACC_SRC_ZERO;
      end
      STEP_MUL_A2: begin
        w.mul_en  = 1'b1;
        w.mul_sel = COEF_A2;
        w.mul_y   = 1'b1;
        w.acc_en  = 1'b1;
        w.acc_dst = 1'b1;
        w.acc_src = ACC_SRC_SELF;
        w.acc_sub = 1'b1;
      end
      STEP_FB_TWO: begin
        w.acc_en  = 1'b1;
        w.acc_dst = 1'b0;
        w.acc_src = ACC_SRC_SELF;
        w.acc_sub = 1'b1;
      end
      STEP_COMMIT: begin
        w.commit   = 1'b1;
        w.jmp_cond = JMP_OUT_FULL;
        w.jmp_tgt  = STEP_COMMIT;
      end
      default: begin
        w.jmp_tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/bqd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_datapath
// Shared multiplier, two wide accumulators, output rounding and state update.
// ----------------------------------------------------------------------------
module bqd_datapath #(
  parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = bqd_pkg::ACC_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bqd_pkg::dp_ctrl_t                      ctrl,
  input  logic signed [bqd_pkg::COEF_WIDTH-1:0]  coef [bqd_pkg::NUM_COEF],
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_x_in,
  output logic signed [SAMPLE_WIDTH-1:0]         y_out,
  output logic                                   clip_out
);

  localparam int CW    = bqd_pkg::COEF_WIDTH;
  localparam int PW    = CW + SAMPLE_WIDTH;
  localparam int EXT_W = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 2;

  localparam logic signed [EXT_W-1:0] ROUND_BIAS =
    {{(EXT_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0]    S_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0]    S_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [PW-1:0]           prod;
  logic signed [EXT_W-1:0]        acc [2];
  logic signed [ACC_WIDTH-1:0]    s1;
  logic signed [ACC_WIDTH-1:0]    s2;
  logic                           clip_seen;

  logic signed [CW-1:0]           coef_pick;
  logic signed [SAMPLE_WIDTH-1:0] mul_op;
  logic signed [PW-1:0]           mul_a;
  logic signed [PW-1:0]           mul_b;
  logic signed [PW-1:0]           prod_full;
  logic signed [EXT_W-1:0]        prod_ext;
  logic signed [EXT_W-1:0]        s1_ext;
  logic signed [EXT_W-1:0]        s2_ext;
  logic signed [EXT_W-1:0]        acc_base;
  logic signed [EXT_W-1:0]        acc_sum;
  logic signed [EXT_W-1:0]        rounded;
  logic                           y_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           s1_ovf;
  logic                           s2_ovf;
  logic signed [ACC_WIDTH-1:0]    s1_sat;
  logic signed [ACC_WIDTH-1:0]    s2_sat;

  // Multiplier operands
  always_comb begin
    unique case (ctrl.mul_sel)
      bqd_pkg::COEF_B0: coef_pick = coef[bqd_pkg::COEF_B0];
      bqd_pkg::COEF_B1: coef_pick = coef[bqd_pkg::COEF_B1];
      bqd_pkg::COEF_B2: coef_pick = coef[bqd_pkg::COEF_B2];
      bqd_pkg::COEF_A1: coef_pick = coef[bqd_pkg::COEF_A1];
      bqd_pkg::COEF_A2: coef_pick = coef[bqd_pkg::COEF_A2];
      default:          coef_pick = '0;
    endcase
  end

  assign mul_op    = ctrl.mul_y ? sample_y : sample_x;
  assign mul_a     = {{SAMPLE_WIDTH{coef_pick[CW-1]}}, coef_pick};
  assign mul_b     = {{CW{mul_op[SAMPLE_WIDTH-1]}}, mul_op};
  assign prod_full = mul_a * mul_b;

  assign prod_ext = {{(EXT_W-PW){prod[PW-1]}}, prod};
  assign s1_ext   = {{(EXT_W-ACC_WIDTH){s1[ACC_WIDTH-1]}}, s1};
  assign s2_ext   = {{(EXT_W-ACC_WIDTH){s2[ACC_WIDTH-1]}}, s2};

  always_comb begin
    case (ctrl.acc_src)
      bqd_pkg::ACC_SRC_S1_RND: acc_base = s1_ext + ROUND_BIAS;
      bqd_pkg::ACC_SRC_S2:     acc_base = s2_ext;
      bqd_pkg::ACC_SRC_SELF:   acc_base = acc[ctrl.acc_dst];
      default:                 acc_base = '0;
    endcase
  end

  assign acc_sum = ctrl.acc_sub ? (acc_base - prod_ext) : (acc_base + prod_ext);

  // Output: bias already added, so floor shift gives round half up
  assign rounded = acc[0] >>> COEF_FRAC_BITS;
  assign y_ovf   = !((&rounded[EXT_W-1:SAMPLE_WIDTH-1]) ||
                     (~|rounded[EXT_W-1:SAMPLE_WIDTH-1]));
  assign y_sat   = y_ovf ? (rounded[EXT_W-1] ? Y_MIN : Y_MAX)
                         : rounded[SAMPLE_WIDTH-1:0];

  // New state: acc[1] holds s1', acc[0] holds s2'
  assign s1_ovf = !((&acc[1][EXT_W-1:ACC_WIDTH-1]) || (~|acc[1][EXT_W-1:ACC_WIDTH-1]));
  assign s2_ovf = !((&acc[0][EXT_W-1:ACC_WIDTH-1]) || (~|acc[0][EXT_W-1:ACC_WIDTH-1]));
  assign s1_sat = s1_ovf ? (acc[1][EXT_W-1] ? S_MIN : S_MAX) : acc[1][ACC_WIDTH-1:0];
  assign s2_sat = s2_ovf ? (acc[0][EXT_W-1] ? S_MIN : S_MAX) : acc[0][ACC_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_x <= sample_x_in;
    end
    if (ctrl.mul_en) begin
      prod <= prod_full;
    end
    if (ctrl.acc_en) begin
      acc[ctrl.acc_dst] <= acc_sum;
    end
    if (ctrl.y_load) begin
      sample_y <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      clip_seen <= 1'b0;
    end else begin
      if (ctrl.load) begin
        clip_seen <= 1'b0;
      end else if (ctrl.y_load && y_ovf) begin
        clip_seen <= 1'b1;
      end
      if (ctrl.commit) begin
        s1 <= s1_sat;
        s2 <= s2_sat;
      end
    end
  end

  assign y_out    = sample_y;
  assign clip_out = clip_seen || s1_ovf || s2_ovf;

endmodule

FILE: src/biquad_tdf2_filter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// biquad_tdf2_filter
// Second-order IIR section, transposed direct form II, microcoded datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample beat: sample_in plus
//   the block_end mark. Output channel (out_valid/out_ready) returns one beat
//   per input beat: the filtered, saturated sample, a clipped flag (output or
//   either state word saturated) and block_end_out, a copy of the mark.
//   Coefficients b0, b1, b2, a1, a2 (signed Q4.16) are written through
//   cfg_we/cfg_index/cfg_data at indexes 0..4; other indexes are ignored.
//   Write them only while the filter is idle.
//   Sequencing: an 8-step program runs on one shared multiplier (five products,
//   each registered before it is accumulated). The result is registered on
//   the commit step, and a new sample is taken only once the sequencer is
//   back in idle, so the filter works on one sample at a time.
//   Stall: the result sits in an output register; if it has not been taken
//   when the next result is ready, the sequencer holds on its commit step and
//   keeps in_ready low until out_ready frees the register.
//   Reset: state words clear to zero, b0 returns to 1.0 and the other
//   coefficients to zero, giving a pass-through filter.
// ----------------------------------------------------------------------------
module biquad_tdf2_filter #(
  parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = bqd_pkg::ACC_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
  input  logic                                   block_end,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
  output logic                                   clipped,
  output logic                                   block_end_out,
  // coefficient write port
  input  logic                                   cfg_we,
  input  logic [bqd_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic signed [bqd_pkg::COEF_WIDTH-1:0]  cfg_data
);

  // Coefficient registers
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_b0;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_b1;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_b2;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_a1;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_a2;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] coef_bank [bqd_pkg::NUM_COEF];

  // Sequencer
  logic [bqd_pkg::STEP_W-1:0] step;
  logic [bqd_pkg::STEP_W-1:0] step_next;
  bqd_pkg::ucode_t            ucode;
  bqd_pkg::dp_ctrl_t          dp_ctrl;
  logic                       in_fire;
  logic                       jump_taken;
  logic                       block_end_hold;
  logic                       at_commit;
  logic                       commit_stall;

  // Datapath results
  logic signed [SAMPLE_WIDTH-1:0] dp_y;
  logic                           dp_clip;

  // Configuration writes: take at once, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= bqd_pkg::COEF_B0_RESET;
      coef_b1 <= bqd_pkg::COEF_ZERO;
      coef_b2 <= bqd_pkg::COEF_ZERO;
      coef_a1 <= bqd_pkg::COEF_ZERO;
      coef_a2 <= bqd_pkg::COEF_ZERO;
    end else if (cfg_we) begin
      case (cfg_index)
        bqd_pkg::COEF_B0: coef_b0 <= cfg_data;
        bqd_pkg::COEF_B1: coef_b1 <= cfg_data;
        bqd_pkg::COEF_B2: coef_b2 <= cfg_data;
        bqd_pkg::COEF_A1: coef_a1 <= cfg_data;
        bqd_pkg::COEF_A2: coef_a2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign coef_bank[bqd_pkg::COEF_B0] = coef_b0;
  assign coef_bank[bqd_pkg::COEF_B1] = coef_b1;
  assign coef_bank[bqd_pkg::COEF_B2] = coef_b2;
  assign coef_bank[bqd_pkg::COEF_A1] = coef_a1;
  assign coef_bank[bqd_pkg::COEF_A2] = coef_a2;

  // Fetch the control word for the current step.
  assign ucode    = bqd_pkg::ucode_rom(step);
  assign in_ready = (step == bqd_pkg::STEP_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign at_commit    = (step == bqd_pkg::STEP_COMMIT);
  assign commit_stall = at_commit && out_valid && !out_ready;

  // Conditional jump: hold in idle until a sample beat arrives, hold on the
  // commit step while the output register is still full.
  always_comb begin
    case (ucode.jmp_cond)
      bqd_pkg::JMP_NO_IN:    jump_taken = !in_fire;
      bqd_pkg::JMP_OUT_FULL: jump_taken = out_valid && !out_ready;
      default:               jump_taken = 1'b0;
    endcase
  end

  // Program wraps from the commit step back to idle.
  assign step_next = jump_taken ? ucode.jmp_tgt : bqd_pkg::STEP_W'(step + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bqd_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Drive the datapath; commit only when the step actually advances.
  always_comb begin
    dp_ctrl.load    = in_fire;
    dp_ctrl.mul_en  = ucode.mul_en;
    dp_ctrl.mul_sel = ucode.mul_sel;
    dp_ctrl.mul_y   = ucode.mul_y;
    dp_ctrl.acc_en  = ucode.acc_en;
    dp_ctrl.acc_dst = ucode.acc_dst;
    dp_ctrl.acc_src = ucode.acc_src;
    dp_ctrl.acc_sub = ucode.acc_sub;
    dp_ctrl.y_load  = ucode.y_load;
    dp_ctrl.commit  = ucode.commit && !jump_taken;
  end

  bqd_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_WIDTH      (ACC_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (dp_ctrl),
    .coef        (coef_bank),
    .sample_x_in (sample_in),
    .y_out       (dp_y),
    .clip_out    (dp_clip)
  );

  // Hold the block end mark alongside the sample in flight.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      block_end_hold <= block_end;
    end
  end

  // Output register: load on commit, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_ctrl.commit) begin
      sample_out    <= dp_y;
      clipped       <= dp_clip;
      block_end_out <= block_end_hold;
    end
  end

  // An accepted sample always starts the multiply program.
  `BQD_ASSERT_NXT(a_beat_starts_program, clk, rst, in_fire, step == bqd_pkg::STEP_MUL_B0)
  // A new result only appears out of the commit step.
  `BQD_ASSERT_IMP(a_result_from_commit, clk, rst, $rose(out_valid), $past(at_commit))
  // A blocked commit keeps the sequencer parked and the result pending.
  `BQD_ASSERT_NXT(a_commit_holds, clk, rst, commit_stall, at_commit && out_valid)
  // A taken result with nothing new behind it empties the output register.
  `BQD_ASSERT_NXT(a_out_drains, clk, rst, out_valid && out_ready && !dp_ctrl.commit, !out_valid)

endmodule

FILE: tb/sv/biquad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_checker
// Watches the sample, result and coefficient ports of the biquad, predicts
// each filtered sample in fixed point and compares it with the result beats.
// ----------------------------------------------------------------------------
module biquad_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [15:0]                    sample_in,
  input  logic                                  block_end,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [15:0]                    sample_out,
  input  logic                                  clipped,
  input  logic                                  block_end_out,
  input  logic                                  cfg_we,
  input  logic [bqd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic signed [bqd_pkg::COEF_WIDTH-1:0] cfg_data,
  output int                                    fail_count,
  output int                                    pending_count
);

  localparam int     SAMPLE_W    = bqd_pkg::SAMPLE_WIDTH_DEF;
  localparam int     FRAC_W      = bqd_pkg::COEF_FRAC_BITS_DEF;
  localparam int     ACC_W       = bqd_pkg::ACC_WIDTH_DEF;
  localparam longint HALF_LSB    = longint'(1) <<< (FRAC_W - 1);
  localparam int     MAX_REPORTS = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
    logic                       mark;
  } filt_result_t;

  logic signed [bqd_pkg::COEF_WIDTH-1:0] coefs [bqd_pkg::NUM_COEF];
  logic signed [ACC_W-1:0]               delay_one;
  logic signed [ACC_W-1:0]               delay_two;
  filt_result_t                          due_q [$];

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    fail_count = fail_count + 1;
  endtask

  function automatic longint saturate(input longint v, input int w, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One filter step: round the forward sum, then advance both delay words
  // using the saturated output for the feedback terms.
  function automatic filt_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic mark);
    longint       acc;
    longint       y;
    longint       s1_next;
    longint       s2_next;
    logic         hit;
    filt_result_t r;
    hit = 1'b0;
    acc = longint'(coefs[bqd_pkg::COEF_B0]) * longint'(x) + longint'(delay_one);
    y = saturate((acc + HALF_LSB) >>> FRAC_W, SAMPLE_W, hit);
    s1_next = saturate(longint'(delay_two)
                       + longint'(coefs[bqd_pkg::COEF_B1]) * longint'(x)
                       - longint'(coefs[bqd_pkg::COEF_A1]) * y, ACC_W, hit);
    s2_next = saturate(longint'(coefs[bqd_pkg::COEF_B2]) * longint'(x)
                       - longint'(coefs[bqd_pkg::COEF_A2]) * y, ACC_W, hit);
    delay_one = s1_next[ACC_W-1:0];
    delay_two = s2_next[ACC_W-1:0];
    r.sample = y[SAMPLE_W-1:0];
    r.clip   = hit;
    r.mark   = mark;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    filt_result_t want;
    if (rst) begin
      coefs[bqd_pkg::COEF_B0] = bqd_pkg::COEF_B0_RESET;
      coefs[bqd_pkg::COEF_B1] = bqd_pkg::COEF_ZERO;
      coefs[bqd_pkg::COEF_B2] = bqd_pkg::COEF_ZERO;
      coefs[bqd_pkg::COEF_A1] = bqd_pkg::COEF_ZERO;
      coefs[bqd_pkg::COEF_A2] = bqd_pkg::COEF_ZERO;
      delay_one = '0;
      delay_two = '0;
      due_q.delete();
    end else begin
      if (cfg_we && cfg_index < bqd_pkg::NUM_COEF) begin
        coefs[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        due_q.push_back(filter_sample(sample_in, block_end));
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result beat with no sample outstanding");
        end else begin
          want = due_q.pop_front();
          if (sample_out !== want.sample) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want.sample));
          end
          if (clipped !== want.clip) begin
            report_mismatch($sformatf("clipped %b, expected %b", clipped, want.clip));
          end
          if (block_end_out !== want.mark) begin
            report_mismatch($sformatf("block_end_out %b, expected %b", block_end_out,
                                      want.mark));
          end
        end
      end
    end
    // registered so the stimulus side always reads the count of the last edge
    pending_count <= due_q.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples and coefficient sets into the biquad under bursty input and
// stalling output, and lets the checker compare every filtered beat.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SAMPLE_W        = bqd_pkg::SAMPLE_WIDTH_DEF;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES    = 32;
  localparam int LIMIT_CYCLES    = 1000000;

  localparam logic signed [bqd_pkg::COEF_WIDTH-1:0] COEF_MAX =
    {1'b0, {(bqd_pkg::COEF_WIDTH-1){1'b1}}};
  localparam logic signed [bqd_pkg::COEF_WIDTH-1:0] COEF_MIN =
    {1'b1, {(bqd_pkg::COEF_WIDTH-1){1'b0}}};
  localparam logic signed [bqd_pkg::COEF_WIDTH-1:0] COEF_HALF = bqd_pkg::COEF_B0_RESET >>> 1;
  localparam logic signed [SAMPLE_W-1:0]   SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0]   SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // output stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_COIN   = 2'd1,
    RX_LONG   = 2'd2
  } rx_mode_t;

  // flavors of coefficient set for the random phases
  typedef enum logic [1:0] {
    COEFS_STABLE = 2'd0,
    COEFS_WILD   = 2'd1,
    COEFS_CORNER = 2'd2
  } coef_kind_t;

  // sample amplitude flavors
  typedef enum logic [1:0] {
    AMP_FULL  = 2'd0,
    AMP_LOW   = 2'd1,
    AMP_MIXED = 2'd2
  } amp_mode_t;

  logic                                  clk           = 1'b0;
  logic                                  rst           = 1'b1;
  logic                                  in_valid      = 1'b0;
  logic                                  in_ready;
  logic signed [SAMPLE_W-1:0]            sample_in     = '0;
  logic                                  block_end     = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready     = 1'b0;
  logic signed [SAMPLE_W-1:0]            sample_out;
  logic                                  clipped;
  logic                                  block_end_out;
  logic                                  cfg_we        = 1'b0;
  logic [bqd_pkg::CFG_INDEX_W-1:0]       cfg_index     = '0;
  logic signed [bqd_pkg::COEF_WIDTH-1:0] cfg_data      = '0;

  int       fail_count;
  int       pending_count;
  int       cycle_count   = 0;
  rx_mode_t rx_mode       = RX_ALWAYS;
  int       hold_left     = 0;

  // sender burst shaping
  bit tx_idle      = 1'b0;
  int tx_gap_max   = 1;
  int tx_burst_max = 1;
  int burst_left   = 0;

  biquad_tdf2_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .block_end_out (block_end_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  biquad_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .clipped       (clipped),
    .block_end_out (block_end_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run: count edges and give up far beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: hold out_ready for a while, then pick the next level from
  // the current pattern. The long pattern alternates short ready windows with
  // stalls so the filter has to hold on its commit step.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= ~out_ready;
          hold_left <= out_ready ? $urandom_range(0, 40) : $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Write one register; the write lands at the next edge.
  task automatic write_reg(input logic [bqd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic signed [bqd_pkg::COEF_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Load all five coefficients, and now and then a stray write to an index
  // past the list, which must leave the filter untouched.
  task automatic load_coefs(input logic signed [bqd_pkg::COEF_WIDTH-1:0] b0,
                            input logic signed [bqd_pkg::COEF_WIDTH-1:0] b1,
                            input logic signed [bqd_pkg::COEF_WIDTH-1:0] b2,
                            input logic signed [bqd_pkg::COEF_WIDTH-1:0] a1,
                            input logic signed [bqd_pkg::COEF_WIDTH-1:0] a2);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(bqd_pkg::CFG_INDEX_W'($urandom_range(bqd_pkg::NUM_COEF,
                                                      (1 << bqd_pkg::CFG_INDEX_W) - 1)),
                bqd_pkg::COEF_WIDTH'($urandom));
    end
    write_reg(bqd_pkg::COEF_B0, b0);
    write_reg(bqd_pkg::COEF_B1, b1);
    write_reg(bqd_pkg::COEF_B2, b2);
    write_reg(bqd_pkg::COEF_A1, a1);
    write_reg(bqd_pkg::COEF_A2, a2);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [bqd_pkg::COEF_WIDTH-1:0] corner_coef();
    case ($urandom_range(0, 4))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return bqd_pkg::COEF_ZERO;
      3:       return bqd_pkg::COEF_B0_RESET;
      default: return -bqd_pkg::COEF_B0_RESET;
    endcase
  endfunction

  // Build a coefficient set of the requested flavor and load it.
  task automatic load_random_coefs(input coef_kind_t kind);
    int radius;
    int cosine;
    logic signed [bqd_pkg::COEF_WIDTH-1:0] a1;
    logic signed [bqd_pkg::COEF_WIDTH-1:0] a2;
    case (kind)
      COEFS_STABLE: begin
        // poles at radius r < 1: a1 = -2 r cos(w), a2 = r^2, all in Q16
        radius = $urandom_range(32768, 64880);
        cosine = int'($urandom_range(0, 131072)) - 65536;
        a2 = bqd_pkg::COEF_WIDTH'((longint'(radius) * radius) >>> 16);
        a1 = bqd_pkg::COEF_WIDTH'(-((2 * longint'(radius) * cosine) >>> 16));
        load_coefs(bqd_pkg::COEF_WIDTH'(int'($urandom_range(0, 65536)) - 32768),
                   bqd_pkg::COEF_WIDTH'(int'($urandom_range(0, 65536)) - 32768),
                   bqd_pkg::COEF_WIDTH'(int'($urandom_range(0, 65536)) - 32768),
                   a1, a2);
      end
      COEFS_WILD: begin
        load_coefs(bqd_pkg::COEF_WIDTH'($urandom), bqd_pkg::COEF_WIDTH'($urandom),
                   bqd_pkg::COEF_WIDTH'($urandom), bqd_pkg::COEF_WIDTH'($urandom),
                   bqd_pkg::COEF_WIDTH'($urandom));
      end
      default: begin
        load_coefs(corner_coef(), corner_coef(), corner_coef(), corner_coef(),
                   corner_coef());
      end
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input amp_mode_t amp);
    logic signed [SAMPLE_W-1:0] low;
    low = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
    case (amp)
      AMP_FULL: return SAMPLE_W'($urandom);
      AMP_LOW:  return low;
      default: begin
        case ($urandom_range(0, 7)) inside
          0:       return SMP_MAX;
          1:       return SMP_MIN;
          [2:3]:   return low;
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offer one sample beat and hold it until accepted. Between bursts drop
  // valid for a random gap; inside a burst keep valid high across beats.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic mark);
    int gap;
    if (tx_idle && burst_left == 0) begin
      gap = $urandom_range(1, tx_gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, tx_burst_max);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    block_end <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left = burst_left - 1;
  endtask

  // Drop valid and wait until every predicted beat has come back, so the
  // filter is idle before the next coefficient change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int        phase;
    int        n;
    int        buf_left;
    logic      mark;
    amp_mode_t amp;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Pass-through after reset: extremes, zero, +-1, alternating bit patterns.
    // Stray writes to unused indexes must not disturb it.
    rx_mode <= RX_COIN;
    write_reg(bqd_pkg::CFG_INDEX_W'(bqd_pkg::NUM_COEF), COEF_MAX);
    write_reg(bqd_pkg::CFG_INDEX_W'((1 << bqd_pkg::CFG_INDEX_W) - 1), COEF_MIN);
    cfg_we <= 1'b0;
    send_sample('0, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b1);
    send_sample(-SAMPLE_W'(1), 1'b0);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SAMPLE_W'(16'h5555), 1'b0);
    send_sample(SAMPLE_W'(16'hAAAA), 1'b1);
    settle();

    // Gain of one half: exact halves round up, toward zero for negatives.
    load_coefs(COEF_HALF, bqd_pkg::COEF_ZERO, bqd_pkg::COEF_ZERO, bqd_pkg::COEF_ZERO,
               bqd_pkg::COEF_ZERO);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample(-SAMPLE_W'(1), 1'b0);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(-SAMPLE_W'(3), 1'b1);
    settle();

    // Full-scale coefficients of both signs: output clamps and hard feedback.
    rx_mode <= RX_LONG;
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    settle();

    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    settle();

    // Random phases: one coefficient set each, samples grouped into buffers
    // whose last beat carries the end mark, with a little mark noise on top.
    // The first phase runs with no idling on either side.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        tx_idle = 1'b0;
        rx_mode <= RX_ALWAYS;
        load_random_coefs(COEFS_STABLE);
      end else begin
        tx_idle      = ($urandom_range(0, 3) != 0);
        tx_gap_max   = $urandom_range(1, 16);
        tx_burst_max = $urandom_range(1, 24);
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        load_random_coefs(coef_kind_t'($urandom_range(0, 2)));
      end
      burst_left = 0;
      amp = amp_mode_t'($urandom_range(0, 2));
      buf_left = $urandom_range(1, 32);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        buf_left = buf_left - 1;
        mark = (buf_left == 0);
        if (mark) buf_left = $urandom_range(1, 32);
        if ($urandom_range(0, 15) == 0) mark = ~mark;
        send_sample(pick_sample(amp), mark);
      end
      settle();
    end

    // Let any stray beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
